@@ design/psw_pkg.sv @@
// Shared types and constants for the priority schedule block.
package psw_pkg;

   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int INDEX_W = 5;
   localparam int TIME_W  = 21;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // One held job in a cell of the sort chain.
   typedef struct packed {
      logic               valid;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [INDEX_W-1:0] index;
   } job_type;

   // Command broadcast to every cell in a cycle.
   typedef struct packed {
      logic    insert;
      logic    drain;
      job_type job;
   } cell_cmd_type;

endpackage

@@ design/psw_cell.sv @@
// One cell of the insertion sort chain: holds a job, shifts up on insert, down on drain.
module psw_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  psw_pkg::cell_cmd_type cmd,
   input  psw_pkg::job_type      prev_job,
   input  logic                  prev_displaced,
   input  psw_pkg::job_type      next_job,
   output psw_pkg::job_type      job,
   output logic                  displaced
);

   psw_pkg::job_type job_ff;
   psw_pkg::job_type job_in;

   // Strict compare keeps equal priorities in arrival order.
   assign displaced = !job_ff.valid || (job_ff.prio > cmd.job.prio);
   assign job       = job_ff;

   always_comb begin
      job_in = job_ff;
      if (cmd.drain) begin
         job_in = next_job;
      end else if (cmd.insert && displaced) begin
         job_in = prev_displaced ? prev_job : cmd.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff.valid <= 1'b0;
      end else begin
         job_ff <= job_in;
      end
   end

endmodule

@@ design/priority_schedule_wait_times.sv @@
// Top level of the nonpreemptive priority scheduler with a systolic sort chain.
//
// Jobs are loaded one transfer per cycle on the req_ channel while req_stall
// is low; each transfer is placed into its sorted slot in a chain of MAX_JOBS
// cells in the same cycle, so loading runs at one job per clock. Ties keep
// arrival order. The transfer with req_last_item set closes the batch:
// req_stall then goes high and the chain drains one job per cycle from its
// head into the rsp_ output register, except while rsp_stall holds a result.
// Moving the final result into the output register frees the loader, so the
// next batch may begin while that result still waits. Jobs beyond MAX_JOBS
// are dropped and every result of that batch shows rsp_overflow. Waiting and
// turnaround times saturate at their 21-bit maximum.
module priority_schedule_wait_times #(
   parameter int MAX_JOBS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // job input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_burst_time,
   input  logic [7:0]  req_priority_req,
   input  logic        req_last_item,
   // schedule output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_job_number,
   output logic [15:0] rsp_job_burst,
   output logic [7:0]  rsp_job_priority,
   output logic [20:0] rsp_wait_ticks,
   output logic [20:0] rsp_finish_ticks,
   output logic        rsp_overflow,
   output logic        rsp_last_result
);

   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // control
   state_type   state_ff,  state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic        ovf_ff,    ovf_in;
   logic [psw_pkg::TIME_W-1:0] wait_ff, wait_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [psw_pkg::INDEX_W-1:0] num_ff, num_in;
   logic [psw_pkg::BURST_W-1:0] burst_ff, burst_in;
   logic [psw_pkg::PRIO_W-1:0]  prio_ff, prio_in;
   logic [psw_pkg::TIME_W-1:0]  wt_ff, wt_in;
   logic [psw_pkg::TIME_W-1:0]  tat_ff, tat_in;
   logic        rovf_ff, rovf_in;
   logic        rlast_ff, rlast_in;

   logic        accept;
   logic        full;
   logic        out_free;
   logic        pop;
   logic        pop_last;
   logic [psw_pkg::TIME_W:0]   sum;
   logic [psw_pkg::TIME_W-1:0] sum_sat;

   psw_pkg::cell_cmd_type cmd;
   psw_pkg::job_type      cell_job  [MAX_JOBS];
   logic                  cell_disp [MAX_JOBS];

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff >= CNT_W'(MAX_JOBS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_DRAIN) && out_free;
   // head is the final job when the cell behind it is empty
   assign pop_last  = !cell_job[1].valid;

   // broadcast to the chain
   always_comb begin
      cmd.insert    = accept && !full;
      cmd.drain     = pop;
      cmd.job.valid = 1'b1;
      cmd.job.burst = req_burst_time;
      cmd.job.prio  = req_priority_req;
      cmd.job.index = psw_pkg::INDEX_W'(count_ff);
   end

   for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
      psw_pkg::job_type prev_job;
      psw_pkg::job_type next_job;
      logic             prev_disp;

      if (i == 0) begin : g_head
         assign prev_job  = '0;
         assign prev_disp = 1'b0;
      end else begin : g_body
         assign prev_job  = cell_job[i-1];
         assign prev_disp = cell_disp[i-1];
      end

      if (i == MAX_JOBS - 1) begin : g_tail
         assign next_job = '0;
      end else begin : g_mid
         assign next_job = cell_job[i+1];
      end

      psw_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .prev_job       (prev_job),
         .prev_displaced (prev_disp),
         .next_job       (next_job),
         .job            (cell_job[i]),
         .displaced      (cell_disp[i])
      );
   end

   // running wait plus head burst, saturated
   assign sum     = {1'b0, wait_ff} + (psw_pkg::TIME_W + 1)'(cell_job[0].burst);
   assign sum_sat = sum[psw_pkg::TIME_W] ? psw_pkg::TIME_MAX : sum[psw_pkg::TIME_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      num_in       = num_ff;
      burst_in     = burst_ff;
      prio_in      = prio_ff;
      wt_in        = wt_ff;
      tat_in       = tat_ff;
      rovf_in      = rovf_ff;
      rlast_in     = rlast_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (req_last_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (pop) begin
               rsp_valid_in = 1'b1;
               num_in       = cell_job[0].index;
               burst_in     = cell_job[0].burst;
               prio_in      = cell_job[0].prio;
               wt_in        = wait_ff;
               tat_in       = sum_sat;
               rovf_in      = ovf_ff;
               rlast_in     = pop_last;
               wait_in      = sum_sat;
               if (pop_last) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  wait_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      burst_ff <= burst_in;
      prio_ff  <= prio_in;
      wt_ff    <= wt_in;
      tat_ff   <= tat_in;
      rovf_ff  <= rovf_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_job_number   = num_ff;
   assign rsp_job_burst    = burst_ff;
   assign rsp_job_priority = prio_ff;
   assign rsp_wait_ticks   = wt_ff;
   assign rsp_finish_ticks = tat_ff;
   assign rsp_overflow     = rovf_ff;
   assign rsp_last_result  = rlast_ff;

endmodule

@@ design/psw_checker.sv @@
// Port-level checker for the priority scheduler, bound to the top level.
module psw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_job_burst,
   input logic [20:0] rsp_wait_ticks,
   input logic [20:0] rsp_finish_ticks,
   input logic        rsp_last_result
);

   logic [21:0] tat_sum;
   assign tat_sum = {1'b0, rsp_wait_ticks} + {6'd0, rsp_job_burst};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_finish_ticks))
      else $error("stalled result changed");

   a_tat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_finish_ticks == tat_sum[20:0] && !tat_sum[21])
                    || rsp_finish_ticks == 21'h1FFFFF)
      else $error("turnaround is not waiting plus burst");

   a_no_load_mid_schedule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> req_stall)
      else $error("input open while schedule drains");

   a_wait_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_result
      |=> rsp_valid && rsp_wait_ticks == $past(rsp_finish_ticks))
      else $error("waiting time does not follow previous turnaround");

endmodule

bind priority_schedule_wait_times psw_checker u_psw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_job_burst    (rsp_job_burst),
   .rsp_wait_ticks   (rsp_wait_ticks),
   .rsp_finish_ticks (rsp_finish_ticks),
   .rsp_last_result  (rsp_last_result)
);
